[design/pti_pkg.sv]
// ----------------------------------------------------------------------------
// pti_pkg
// shared types and codes for the prefix tree insert / search block
// ----------------------------------------------------------------------------
package pti_pkg;

  // beat widths
  localparam int unsigned SYM_W      = 8;
  localparam int unsigned SYM_CODES  = 256;
  localparam int unsigned FUNC_W     = 2;
  localparam int unsigned IN_USER_W  = 3;
  localparam int unsigned OUT_DATA_W = 8;

  // word operation codes
  localparam logic [FUNC_W-1:0] FUNC_INSERT = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_SEARCH = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_PREFIX = 2'd2;
  localparam logic [FUNC_W-1:0] FUNC_RSVD   = 2'd3;

  // tuser bit positions on the input side
  localparam int unsigned USER_FUNC_LSB  = 0;
  localparam int unsigned USER_EMPTY_BIT = 2;

  // tdata bit positions on the output side
  localparam int unsigned OUT_FOUND_BIT = 0;
  localparam int unsigned OUT_FULL_BIT  = 1;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOOK,
    ST_FINAL,
    ST_MARK,
    ST_RESP
  } pti_state_t;

endpackage

[design/prefix_tree_insert_search.sv]
// ----------------------------------------------------------------------------
// prefix_tree_insert_search
// prefix tree held in a child table memory, walked one character per beat
// ----------------------------------------------------------------------------
//
//  channel | direction | tdata                       | tuser                      | tlast
//  --------+-----------+-----------------------------+----------------------------+-----------
//  in_     | slave     | [7:0] symbol                | [1:0] func, [2] empty_word | last char
//  out_    | master    | [0] found, [1] table_full   | -                          | -
//
//  a character beat is accepted and then looked up in the child table (one
//  memory read, then the optional write of a newly allocated child)
//  the final beat of a word then passes a result decision and an output load,
//  with a second read from the end mark memory between them for an exact search
//  after reset a clearing pass over all MAX_NODES*ALPHABET_SIZE slots zeroes both
//  memories; no beat is taken until it finishes
//  the result sits in an output register, so new beats are taken while it
//  waits; only a second result stalls until the first one is taken
//
module prefix_tree_insert_search #(
  parameter int unsigned MAX_NODES     = 256,
  parameter int unsigned ALPHABET_SIZE = 256
) (
  input  logic                               clk,
  input  logic                               rst_n,
  // input beats
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [pti_pkg::SYM_W-1:0]          in_tdata,   // [7:0] symbol
  input  logic [pti_pkg::IN_USER_W-1:0]      in_tuser,   // [1:0] func, [2] empty_word
  input  logic                               in_tlast,
  // result beats
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [pti_pkg::OUT_DATA_W-1:0]     out_tdata   // [0] found, [1] table_full
);

  // node index, allocation count, table address and symbol widths
  localparam int unsigned NW          = $clog2(MAX_NODES);
  localparam int unsigned CNT_W       = $clog2(MAX_NODES + 1);
  localparam int unsigned TABLE_DEPTH = MAX_NODES * ALPHABET_SIZE;
  localparam int unsigned AW          = $clog2(TABLE_DEPTH);
  localparam int unsigned SW          = $clog2(ALPHABET_SIZE);

  localparam logic [AW-1:0]    LAST_ADDR = AW'(TABLE_DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT  = CNT_W'(MAX_NODES);

  // control state
  pti_pkg::pti_state_t    state_r, state_nxt;
  logic [AW-1:0]          sweep_r, sweep_nxt;
  logic [NW-1:0]          cur_r, cur_nxt;
  logic [CNT_W-1:0]       used_r, used_nxt;
  logic                   failed_r, failed_nxt;
  logic                   ovf_r, ovf_nxt;
  logic                   out_valid_r, out_valid_nxt;

  // per-beat payload
  logic [pti_pkg::FUNC_W-1:0] op_r, op_nxt;
  logic                   fin_r, fin_nxt;
  logic [AW-1:0]          addr_r, addr_nxt;
  logic                   hit_r, hit_nxt;
  logic                   full_r, full_nxt;
  logic                   found_out_r, found_out_nxt;
  logic                   full_out_r, full_out_nxt;

  // memories and their ports
  logic [NW-1:0]          child_mem [TABLE_DEPTH];
  logic                   mark_mem  [MAX_NODES];
  logic [NW-1:0]          child_q_r;
  logic                   mark_q_r;
  logic                   child_we, child_re;
  logic [AW-1:0]          child_wa, child_ra;
  logic [NW-1:0]          child_wd;
  logic                   mark_we, mark_re;
  logic [NW-1:0]          mark_wa, mark_ra;
  logic                   mark_wd;

  // decoded input beat
  logic [pti_pkg::FUNC_W-1:0] in_func, in_op;
  logic                   in_empty;
  logic [SW-1:0]          sym_mod_tab [pti_pkg::SYM_CODES];
  logic [AW-1:0]          look_addr;
  logic                   stopped;

  // symbol reduced into the alphabet, as a constant lookup
  for (genvar g = 0; g < pti_pkg::SYM_CODES; g++) begin : g_sym_mod
    assign sym_mod_tab[g] = SW'(g % ALPHABET_SIZE);
  end

  assign in_func   = in_tuser[pti_pkg::USER_FUNC_LSB +: pti_pkg::FUNC_W];
  assign in_empty  = in_tuser[pti_pkg::USER_EMPTY_BIT];
  // the spare code behaves as a prefix query
  assign in_op     = (in_func == pti_pkg::FUNC_RSVD) ? pti_pkg::FUNC_PREFIX : in_func;
  // slot of (current node, symbol) in the child table
  assign look_addr = AW'(AW'(cur_r) * AW'(ALPHABET_SIZE)) + AW'(sym_mod_tab[in_tdata]);
  // a missing edge or an exhausted table ends the walk for this word
  assign stopped   = failed_r | ovf_r;

  assign out_tvalid = out_valid_r;
  always_comb begin
    out_tdata = '0;
    out_tdata[pti_pkg::OUT_FOUND_BIT] = found_out_r;
    out_tdata[pti_pkg::OUT_FULL_BIT]  = full_out_r;
  end

  // next state and memory controls
  always_comb begin
    state_nxt     = state_r;
    sweep_nxt     = sweep_r;
    cur_nxt       = cur_r;
    used_nxt      = used_r;
    failed_nxt    = failed_r;
    ovf_nxt       = ovf_r;
    op_nxt        = op_r;
    fin_nxt       = fin_r;
    addr_nxt      = addr_r;
    hit_nxt       = hit_r;
    full_nxt      = full_r;
    out_valid_nxt = out_valid_r & ~out_tready;
    found_out_nxt = found_out_r;
    full_out_nxt  = full_out_r;
    in_tready     = 1'b0;
    child_we      = 1'b0;
    child_wa      = addr_r;
    child_wd      = '0;
    child_re      = 1'b0;
    child_ra      = look_addr;
    mark_we       = 1'b0;
    mark_wa       = cur_r;
    mark_wd       = 1'b0;
    mark_re       = 1'b0;
    mark_ra       = cur_r;

    case (state_r)
      pti_pkg::ST_CLEAR: begin
        // zero one child slot and one end mark per cycle
        child_we = 1'b1;
        child_wa = sweep_r;
        mark_we  = 1'b1;
        mark_wa  = sweep_r[NW-1:0];
        if (sweep_r == LAST_ADDR) begin
          state_nxt = pti_pkg::ST_IDLE;
        end else begin
          sweep_nxt = sweep_r + AW'(1);
        end
      end
      pti_pkg::ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          op_nxt   = in_op;
          fin_nxt  = in_tlast;
          addr_nxt = look_addr;
          if (!in_empty && !stopped) begin
            child_re  = 1'b1;
            state_nxt = pti_pkg::ST_LOOK;
          end else if (in_tlast) begin
            state_nxt = pti_pkg::ST_FINAL;
          end
        end
      end
      pti_pkg::ST_LOOK: begin
        if (child_q_r == '0) begin
          if (op_r != pti_pkg::FUNC_INSERT) begin
            failed_nxt = 1'b1;
          end else if (used_r == FULL_CNT) begin
            ovf_nxt = 1'b1;
          end else begin
            // allocate the next free node as the child
            child_we = 1'b1;
            child_wd = used_r[NW-1:0];
            cur_nxt  = used_r[NW-1:0];
            used_nxt = used_r + CNT_W'(1);
          end
        end else begin
          cur_nxt = child_q_r;
        end
        state_nxt = fin_r ? pti_pkg::ST_FINAL : pti_pkg::ST_IDLE;
      end
      pti_pkg::ST_FINAL: begin
        if (op_r == pti_pkg::FUNC_SEARCH && !stopped) begin
          mark_re   = 1'b1;
          state_nxt = pti_pkg::ST_MARK;
        end else begin
          hit_nxt  = !stopped && (op_r != pti_pkg::FUNC_SEARCH);
          full_nxt = (op_r == pti_pkg::FUNC_INSERT) && ovf_r;
          if (op_r == pti_pkg::FUNC_INSERT && !stopped) begin
            mark_we = 1'b1;
            mark_wd = 1'b1;
          end
          state_nxt = pti_pkg::ST_RESP;
        end
      end
      pti_pkg::ST_MARK: begin
        hit_nxt   = mark_q_r;
        full_nxt  = 1'b0;
        state_nxt = pti_pkg::ST_RESP;
      end
      pti_pkg::ST_RESP: begin
        // load the result once the output register is free, walk back to root
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          found_out_nxt = hit_r;
          full_out_nxt  = full_r;
          cur_nxt       = '0;
          failed_nxt    = 1'b0;
          ovf_nxt       = 1'b0;
          state_nxt     = pti_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = pti_pkg::ST_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= pti_pkg::ST_CLEAR;
      sweep_r     <= '0;
      cur_r       <= '0;
      used_r      <= CNT_W'(1);
      failed_r    <= 1'b0;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      sweep_r     <= sweep_nxt;
      cur_r       <= cur_nxt;
      used_r      <= used_nxt;
      failed_r    <= failed_nxt;
      ovf_r       <= ovf_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    op_r        <= op_nxt;
    fin_r       <= fin_nxt;
    addr_r      <= addr_nxt;
    hit_r       <= hit_nxt;
    full_r      <= full_nxt;
    found_out_r <= found_out_nxt;
    full_out_r  <= full_out_nxt;
  end

  // child table: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (child_we) begin
      child_mem[child_wa] <= child_wd;
    end
    if (child_re) begin
      child_q_r <= child_mem[child_ra];
    end
  end

  // end marks: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (mark_we) begin
      mark_mem[mark_wa] <= mark_wd;
    end
    if (mark_re) begin
      mark_q_r <= mark_mem[mark_ra];
    end
  end

`ifndef NO_ASSERTIONS
  // allocation count stays between the root alone and a full table
  a_used_range: assert property (@(posedge clk) disable iff (!rst_n)
    (used_r != '0) && (used_r <= FULL_CNT))
    else $error("node count out of range");

  // the walk only ever sits on an allocated node
  a_cur_allocated: assert property (@(posedge clk) disable iff (!rst_n)
    CNT_W'(cur_r) < used_r)
    else $error("walk on an unallocated node");

  // new children only come from an insert with room left
  a_alloc_legal: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == pti_pkg::ST_LOOK) && child_we |->
      (op_r == pti_pkg::FUNC_INSERT) && (used_r != FULL_CNT))
    else $error("child allocated without room or outside insert");

  // a delivered result returns the walk to a clean root
  a_resp_resets_walk: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == pti_pkg::ST_RESP) && (!out_valid_r || out_tready) |=>
      out_tvalid && (cur_r == '0) && !failed_r && !ovf_r)
    else $error("walk not back at root after result");

  // nothing comes out during the clearing pass
  a_clear_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == pti_pkg::ST_CLEAR) |-> !out_tvalid && !in_tready)
    else $error("traffic during clearing pass");
`endif

endmodule

[sim/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// checks the prefix tree block with streamed words of insert, exact search
// and prefix query beats; a local copy of the tree predicts every result,
// and results are compared field by field in arrival order
// ----------------------------------------------------------------------------
module testbench;

  localparam int unsigned NODES      = 256;
  localparam int unsigned CHARS      = 256;
  localparam int unsigned CYCLE_LIMIT = 1000000;
  localparam int unsigned DRAIN_WAIT  = 40;
  localparam int unsigned LONG_HOLD   = 600;

  // one input beat: a character (or an empty marker) of a word
  typedef struct {
    logic [pti_pkg::FUNC_W-1:0] func;
    logic [pti_pkg::SYM_W-1:0]  sym;
    logic                       last;
    logic                       empty;
  } char_beat_t;

  // one result beat
  typedef struct {
    bit found;
    bit full;
  } trie_answer_t;

  // a word of up to four characters
  typedef struct {
    int unsigned      len;
    logic [3:0][7:0]  ch;
  } word_t;

  logic                           clk = 1'b0;
  logic                           rst_n = 1'b0;
  logic                           in_tvalid = 1'b0;
  logic                           in_tready;
  logic [pti_pkg::SYM_W-1:0]      in_tdata = '0;      // [7:0] symbol
  logic [pti_pkg::IN_USER_W-1:0]  in_tuser = '0;      // [1:0] func, [2] empty_word
  logic                           in_tlast = 1'b0;
  logic                           out_tvalid;
  logic                           out_tready = 1'b0;
  logic [pti_pkg::OUT_DATA_W-1:0] out_tdata;          // [0] found, [1] table_full

  prefix_tree_insert_search dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .in_tlast  (in_tlast),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // local copy of the tree
  // ---------------------------------------------------------------------------
  bit [7:0] child_of [NODES*CHARS];   // 0 means no child
  bit       word_ends [NODES];
  int unsigned nodes_used = 1;
  int unsigned cur_node   = 0;
  bit walk_failed     = 1'b0;
  bit insert_overflow = 1'b0;

  // walk one beat through the tree; a final beat yields an answer
  function automatic void trie_walk(input char_beat_t b, output bit has_answer,
                                    output trie_answer_t ans);
    logic [pti_pkg::FUNC_W-1:0] op;
    int unsigned slot;
    int unsigned nxt;
    bit stopped;
    op = (b.func == pti_pkg::FUNC_RSVD) ? pti_pkg::FUNC_PREFIX : b.func;
    has_answer = 1'b0;
    ans = '{found: 1'b0, full: 1'b0};
    if (!b.empty && !walk_failed && !insert_overflow) begin
      slot = cur_node * CHARS + b.sym;
      nxt  = child_of[slot];
      if (nxt == 0) begin
        if (op != pti_pkg::FUNC_INSERT) begin
          walk_failed = 1'b1;
        end else if (nodes_used >= NODES) begin
          // no free node left: the rest of this word is dropped
          insert_overflow = 1'b1;
        end else begin
          nxt = nodes_used;
          nodes_used++;
          child_of[slot] = nxt[7:0];
        end
      end
      if (!walk_failed && !insert_overflow) cur_node = nxt;
    end
    if (b.last) begin
      has_answer = 1'b1;
      stopped = walk_failed || insert_overflow;
      case (op)
        pti_pkg::FUNC_INSERT: begin
          ans.full = insert_overflow;
          if (!stopped) begin
            word_ends[cur_node] = 1'b1;
            ans.found = 1'b1;
          end
        end
        pti_pkg::FUNC_SEARCH: ans.found = !stopped && word_ends[cur_node];
        default:              ans.found = !stopped;
      endcase
      // back to the root for the next word
      cur_node        = 0;
      walk_failed     = 1'b0;
      insert_overflow = 1'b0;
    end
  endfunction

  // ---------------------------------------------------------------------------
  // shared state between stimulus, driver and monitor
  // ---------------------------------------------------------------------------
  char_beat_t   char_beats[$];       // beats waiting to be driven
  trie_answer_t pending_answers[$];  // predicted results not yet seen
  bit           in_beat_taken = 1'b0;
  int unsigned  in_idle_pct  = 0;
  int unsigned  out_idle_pct = 0;
  bit           hold_request = 1'b0;
  int unsigned  hold_left    = 0;
  int unsigned  mismatches   = 0;

  task automatic report_mismatch(input string what, input int exp_v, input int act_v);
    mismatches++;
    if (mismatches <= 10)
      $display("mismatch at %0t: %s expected %0d got %0d", $time, what, exp_v, act_v);
  endtask

  // ---------------------------------------------------------------------------
  // driver: input beats change on the falling edge
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin : drive_in
    char_beat_t b;
    // a beat still waiting for tready stays on the bus
    if (rst_n && !(in_tvalid && !in_beat_taken)) begin
      if (char_beats.size() != 0 && $urandom_range(99) >= in_idle_pct) begin
        b = char_beats.pop_front();
        in_tvalid <= 1'b1;
        in_tdata  <= b.sym;
        in_tuser  <= {b.empty, b.func};
        in_tlast  <= b.last;
      end else begin
        in_tvalid <= 1'b0;
      end
    end
    in_beat_taken = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // receiver back-pressure, with an occasional long hold counted here
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin : drive_out_ready
    if (hold_request) begin
      hold_left = LONG_HOLD;
      hold_request = 1'b0;
    end else if (hold_left != 0) begin
      hold_left = hold_left - 1;
    end
    out_tready <= rst_n && (hold_left == 0) && ($urandom_range(99) >= out_idle_pct);
  end

  // ---------------------------------------------------------------------------
  // monitor: handshakes sampled on the rising edge
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : watch
    char_beat_t b;
    bit has_answer;
    trie_answer_t ans;
    trie_answer_t want;
    logic [pti_pkg::OUT_DATA_W-1:0] pad;
    if (rst_n) begin
      // compare first so a beat predicted at this edge never meets an older result
      if (out_tvalid && out_tready) begin
        if (pending_answers.size() == 0) begin
          report_mismatch("result with nothing pending, tdata", 0, int'(out_tdata));
        end else begin
          want = pending_answers.pop_front();
          if (out_tdata[pti_pkg::OUT_FOUND_BIT] !== want.found)
            report_mismatch("found", int'(want.found),
                            int'(out_tdata[pti_pkg::OUT_FOUND_BIT]));
          if (out_tdata[pti_pkg::OUT_FULL_BIT] !== want.full)
            report_mismatch("table_full", int'(want.full),
                            int'(out_tdata[pti_pkg::OUT_FULL_BIT]));
          pad = out_tdata;
          pad[pti_pkg::OUT_FOUND_BIT] = 1'b0;
          pad[pti_pkg::OUT_FULL_BIT]  = 1'b0;
          if (pad !== '0) report_mismatch("tdata padding", 0, int'(pad));
        end
      end
      if (in_tvalid && in_tready) begin
        b.func  = in_tuser[pti_pkg::USER_FUNC_LSB +: pti_pkg::FUNC_W];
        b.sym   = in_tdata;
        b.last  = in_tlast;
        b.empty = in_tuser[pti_pkg::USER_EMPTY_BIT];
        trie_walk(b, has_answer, ans);
        if (has_answer) pending_answers.push_back(ans);
        in_beat_taken = 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus
  // ---------------------------------------------------------------------------
  logic [7:0] sym_pool [8] = '{8'h00, 8'hFF, 8'h55, 8'hAA, 8'h61, 8'h62, 8'h63, 8'h0F};
  word_t known_words[$];

  task automatic push_beat(input logic [pti_pkg::FUNC_W-1:0] func, input logic [7:0] sym,
                           input logic last, input logic empty);
    char_beats.push_back('{func: func, sym: sym, last: last, empty: empty});
  endtask

  // one word; a noisy word changes func per beat and slips in empty beats
  task automatic push_word(input logic [pti_pkg::FUNC_W-1:0] op, input word_t w,
                           input bit noisy);
    logic [pti_pkg::FUNC_W-1:0] f;
    if (w.len == 0) begin
      push_beat(op, 8'($urandom_range(255)), 1'b1, 1'b1);
    end else begin
      for (int unsigned i = 0; i < w.len; i++) begin
        f = op;
        if (noisy) begin
          if ($urandom_range(3) == 0) push_beat(2'($urandom_range(3)),
                                                8'($urandom_range(255)), 1'b0, 1'b1);
          if (i + 1 < w.len) f = 2'($urandom_range(3));
        end
        push_beat(f, w.ch[i], i + 1 == w.len, 1'b0);
      end
    end
  endtask

  // random words until about n counted beats are queued
  task automatic push_random_words(input int unsigned n);
    int unsigned made;
    int unsigned roll;
    logic [pti_pkg::FUNC_W-1:0] op;
    word_t w;
    made = 0;
    while (made < n) begin
      w.len = ($urandom_range(99) < 5) ? 0 : $urandom_range(1, 4);
      for (int i = 0; i < 4; i++)
        w.ch[i] = ($urandom_range(9) < 7) ? sym_pool[$urandom_range(7)]
                                          : 8'($urandom_range(255));
      roll = $urandom_range(99);
      if (roll < 40)      op = pti_pkg::FUNC_INSERT;
      else if (roll < 70) op = pti_pkg::FUNC_SEARCH;
      else if (roll < 95) op = pti_pkg::FUNC_PREFIX;
      else                op = pti_pkg::FUNC_RSVD;
      // queries mostly ask for stored words, prefix queries for parts of them
      if (op != pti_pkg::FUNC_INSERT && known_words.size() != 0 &&
          $urandom_range(99) < 60) begin
        w = known_words[$urandom_range(known_words.size() - 1)];
        if (op != pti_pkg::FUNC_SEARCH) w.len = $urandom_range(w.len);
      end
      if (op == pti_pkg::FUNC_INSERT && w.len != 0) begin
        known_words.push_back(w);
        if (known_words.size() > 64) void'(known_words.pop_front());
      end
      push_word(op, w, $urandom_range(99) < 10);
      made += (w.len == 0) ? 1 : w.len;
    end
  endtask

  task automatic wait_all_done();
    while (char_beats.size() != 0 || in_tvalid || pending_answers.size() != 0)
      @(posedge clk);
  endtask

  initial begin : stimulus
    repeat (11) @(negedge clk);
    rst_n <= 1'b1;

    // first phase: sender idles a little, receiver a lot
    in_idle_pct  = 31;
    out_idle_pct = 76;

    // empty word acts on the root
    push_beat(pti_pkg::FUNC_INSERT, 8'hA5, 1'b1, 1'b1);
    push_beat(pti_pkg::FUNC_SEARCH, 8'h00, 1'b1, 1'b1);
    push_beat(pti_pkg::FUNC_PREFIX, 8'hFF, 1'b1, 1'b1);
    // search before the word exists misses
    push_beat(pti_pkg::FUNC_SEARCH, 8'h00, 1'b0, 1'b0);
    push_beat(pti_pkg::FUNC_SEARCH, 8'hFF, 1'b1, 1'b0);
    // insert, then find it again
    push_beat(pti_pkg::FUNC_INSERT, 8'h00, 1'b0, 1'b0);
    push_beat(pti_pkg::FUNC_INSERT, 8'hFF, 1'b1, 1'b0);
    push_beat(pti_pkg::FUNC_SEARCH, 8'h00, 1'b0, 1'b0);
    push_beat(pti_pkg::FUNC_SEARCH, 8'hFF, 1'b1, 1'b0);
    // reserved func behaves as a prefix query
    push_beat(pti_pkg::FUNC_RSVD, 8'h00, 1'b1, 1'b0);
    // a stored prefix without an end mark is not a word
    push_beat(pti_pkg::FUNC_SEARCH, 8'h00, 1'b1, 1'b0);
    // empty beat without last in the middle of a word is ignored
    push_beat(pti_pkg::FUNC_INSERT, 8'hAA, 1'b0, 1'b0);
    push_beat(pti_pkg::FUNC_INSERT, 8'h3C, 1'b0, 1'b1);
    push_beat(pti_pkg::FUNC_INSERT, 8'h55, 1'b1, 1'b0);
    // func switching inside a word: walk as search, finish as insert
    push_beat(pti_pkg::FUNC_SEARCH, 8'h00, 1'b0, 1'b0);
    push_beat(pti_pkg::FUNC_INSERT, 8'h7E, 1'b1, 1'b0);
    // insert step, then a search step on a missing edge stops the walk
    push_beat(pti_pkg::FUNC_INSERT, 8'h33, 1'b0, 1'b0);
    push_beat(pti_pkg::FUNC_SEARCH, 8'h44, 1'b1, 1'b0);
    // a stopped walk skips a later insert step; insert answer is a miss
    push_beat(pti_pkg::FUNC_PREFIX, 8'h99, 1'b0, 1'b0);
    push_beat(pti_pkg::FUNC_INSERT, 8'h01, 1'b1, 1'b0);
    // prefix query on a missing edge
    push_beat(pti_pkg::FUNC_PREFIX, 8'h12, 1'b1, 1'b0);
    push_random_words(530);
    wait_all_done();

    // second phase: roles swapped; sender waited for every result above
    in_idle_pct  = 76;
    out_idle_pct = 31;
    push_random_words(550);
    wait_all_done();

    // third phase: no idling, with a long receiver hold so the input backs up
    in_idle_pct  = 0;
    out_idle_pct = 0;
    @(posedge clk);
    hold_request = 1'b1;
    push_random_words(550);
    wait_all_done();

    repeat (DRAIN_WAIT) @(posedge clk);
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // watchdog; allows for the table clearing pass after reset
  initial begin : watchdog
    #(CYCLE_LIMIT * 10);
    $display("FAILURE");
    $finish;
  end

endmodule
